// File: design/sac_pkg.sv
`default_nettype none

package sac_pkg;

    // Geometry of the tag store
    localparam int SETS      = 1024;
    localparam int WAYS      = 8;
    localparam int ADDR_BITS = 32;
    localparam int TAG_W     = 28;
    localparam int SET_BITS  = $clog2(SETS);
    localparam int WAY_BITS  = $clog2(WAYS);
    localparam int CFG_BITS  = 4;

    // Legal ranges of the configuration fields
    localparam logic [CFG_BITS-1:0] OFF_MIN    = 4'd4;
    localparam logic [CFG_BITS-1:0] OFF_MAX    = 4'd8;
    localparam logic [CFG_BITS-1:0] IDX_MAX    = CFG_BITS'(SET_BITS);
    localparam logic [CFG_BITS-1:0] NW_MAX     = CFG_BITS'(WAYS);
    localparam logic [WAY_BITS-1:0] RANK_MAX   = WAY_BITS'(WAYS - 1);

    // Access kinds
    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_STORE = 2'd1,
        KIND_FETCH = 2'd2
    } t_kind;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_INDEX_BITS  = 2'd1,
        CFG_WAYS_IN_USE = 2'd2
    } t_cfg_idx;

    // One way of a set
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic                valid;
        logic                dirty;
        logic [WAY_BITS-1:0] rank;
    } t_line;

    // One set, as stored in one RAM row
    typedef t_line [WAYS-1:0] t_row;

    localparam int ROW_BITS = $bits(t_row);

    // Outcome of one access
    typedef struct packed {
        logic [1:0]          kind;
        logic                hit;
        logic                writeback;
        logic [WAY_BITS-1:0] way;
    } t_result;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

`default_nettype wire

// File: design/sac_ram.sv
`default_nettype none

module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/sac_update.sv
`default_nettype none

module sac_update (
    input  wire sac_pkg::t_row                     i_row,
    input  wire logic [sac_pkg::TAG_W-1:0]         i_tag,
    input  wire logic [1:0]                        i_kind,
    input  wire logic [sac_pkg::CFG_BITS-1:0]      i_nw,
    output sac_pkg::t_row                          o_row,
    output sac_pkg::t_result                       o_res
);

    always_comb begin
        logic [sac_pkg::WAYS-1:0]     in_use;
        logic [sac_pkg::WAYS-1:0]     hit_vec;
        logic [sac_pkg::WAYS-1:0]     free_vec;
        logic                         hit;
        logic                         found;
        logic                         store;
        logic [sac_pkg::WAY_BITS-1:0] hit_way;
        logic [sac_pkg::WAY_BITS-1:0] free_way;
        logic [sac_pkg::WAY_BITS-1:0] vic_way;
        logic [sac_pkg::WAY_BITS-1:0] vic_rank;
        logic [sac_pkg::WAY_BITS-1:0] sel;
        logic [sac_pkg::WAY_BITS-1:0] age;
        logic                         bump;

        store = (i_kind == sac_pkg::KIND_STORE);

        // Tag compare and free-way detect over the ways in use
        for (int v = 0; v < sac_pkg::WAYS; v++) begin
            in_use[v]   = (sac_pkg::CFG_BITS'(v) < i_nw);
            hit_vec[v]  = in_use[v] && i_row[v].valid && (i_row[v].tag == i_tag);
            free_vec[v] = in_use[v] && !i_row[v].valid;
        end
        hit   = |hit_vec;
        found = |free_vec;

        // Lowest matching way and lowest free way
        hit_way  = '0;
        free_way = '0;
        for (int v = sac_pkg::WAYS - 1; v >= 0; v--) begin
            if (hit_vec[v]) begin
                hit_way = sac_pkg::WAY_BITS'(v);
            end
            if (free_vec[v]) begin
                free_way = sac_pkg::WAY_BITS'(v);
            end
        end

        // Oldest way, lowest index wins a tie
        vic_way  = '0;
        vic_rank = i_row[0].rank;
        for (int v = 1; v < sac_pkg::WAYS; v++) begin
            if (in_use[v] && (i_row[v].rank > vic_rank)) begin
                vic_way  = sac_pkg::WAY_BITS'(v);
                vic_rank = i_row[v].rank;
            end
        end

        if (hit) begin
            sel = hit_way;
        end else if (found) begin
            sel = free_way;
        end else begin
            sel = vic_way;
        end
        age = i_row[sel].rank;

        // Age the other valid lines; a fill into a free way ages them all
        o_row = i_row;
        for (int v = 0; v < sac_pkg::WAYS; v++) begin
            bump = in_use[v] && i_row[v].valid && (sac_pkg::WAY_BITS'(v) != sel) &&
                   ((found && !hit) || (i_row[v].rank < age));
            if (bump && (i_row[v].rank != sac_pkg::RANK_MAX)) begin
                o_row[v].rank = i_row[v].rank + 1'b1;
            end
        end
        o_row[sel].rank = '0;

        // Line bits of the chosen way
        if (hit) begin
            if (store) begin
                o_row[sel].dirty = 1'b1;
            end
        end else begin
            o_row[sel].valid = 1'b1;
            o_row[sel].tag   = i_tag;
            o_row[sel].dirty = store;
        end

        o_res.kind      = i_kind;
        o_res.hit       = hit;
        o_res.writeback = !hit && !found && i_row[sel].dirty;
        o_res.way       = sel;
    end

endmodule

`default_nettype wire

// File: design/set_assoc_cache_lru_tags_unit.sv
`default_nettype none

// Tag store of a set-associative, write-back, write-allocate cache with LRU
// replacement. Each request (kind, address) returns one result: kind echo,
// hit, writeback of a dirty victim, and the way hit or filled. All sets live
// in one RAM, one row per set holding tag, valid, dirty and LRU age of every
// way. An access is a registered RAM read of the set, then a compare that
// picks the way and writes the row back; the next request is taken in the
// cycle after that write. A result waits in an output register; the next
// request is still taken, but its row write and result wait until the held
// result is taken. After reset a clearing pass writes every row once,
// during which no request is taken. Configuration writes are always
// accepted, but are only to be issued while no request is in flight: the
// lookup uses the way count as currently configured.
module set_assoc_cache_lru_tags_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [1:0]                        i_cfg_index,
    input  wire logic [sac_pkg::CFG_BITS-1:0]      i_cfg_data,
    // request channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_access_kind,
    input  wire logic [sac_pkg::ADDR_BITS-1:0]     i_address,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [1:0]                             o_kind_echo,
    output logic                                   o_hit,
    output logic                                   o_writeback,
    output logic [sac_pkg::WAY_BITS-1:0]           o_way
);

    sac_pkg::t_state                    r_state, n_state;
    logic [sac_pkg::SET_BITS-1:0]       r_clr_addr;
    logic [sac_pkg::CFG_BITS-1:0]       r_offset_bits, r_index_bits, r_ways_in_use;
    logic [sac_pkg::SET_BITS-1:0]       r_set;
    logic [sac_pkg::TAG_W-1:0]          r_tag;
    logic [1:0]                         r_kind;
    logic                               r_out_valid;
    sac_pkg::t_result                   r_res;

    logic [sac_pkg::CFG_BITS-1:0]       off_eff, ib_eff, nw_eff;
    logic [sac_pkg::CFG_BITS:0]         tag_shift;
    logic [sac_pkg::ADDR_BITS-1:0]      addr_sh, tag_sh;
    logic [sac_pkg::SET_BITS-1:0]       set_mask, set_idx;
    logic                               in_acc, out_free, done;
    logic                               ram_we, ram_re;
    logic [sac_pkg::SET_BITS-1:0]       ram_waddr;
    logic [sac_pkg::ROW_BITS-1:0]       ram_wdata, ram_rdata;
    sac_pkg::t_row                      rd_row, upd_row;
    sac_pkg::t_result                   upd_res;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= 4'd4;
            r_index_bits  <= 4'd10;
            r_ways_in_use <= 4'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sac_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                sac_pkg::CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data;
                sac_pkg::CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp configuration into its legal range
    always_comb begin
        if (r_offset_bits < sac_pkg::OFF_MIN) begin
            off_eff = sac_pkg::OFF_MIN;
        end else if (r_offset_bits > sac_pkg::OFF_MAX) begin
            off_eff = sac_pkg::OFF_MAX;
        end else begin
            off_eff = r_offset_bits;
        end
        ib_eff = (r_index_bits > sac_pkg::IDX_MAX) ? sac_pkg::IDX_MAX : r_index_bits;
        if (r_ways_in_use == '0) begin
            nw_eff = 4'd1;
        end else if (r_ways_in_use > sac_pkg::NW_MAX) begin
            nw_eff = sac_pkg::NW_MAX;
        end else begin
            nw_eff = r_ways_in_use;
        end
    end

    // Address split
    assign tag_shift = {1'b0, off_eff} + {1'b0, ib_eff};
    assign addr_sh   = i_address >> off_eff;
    assign tag_sh    = i_address >> tag_shift;
    assign set_mask  = ~({sac_pkg::SET_BITS{1'b1}} << ib_eff);
    assign set_idx   = addr_sh[sac_pkg::SET_BITS-1:0] & set_mask;

    assign o_in_ready = (r_state == sac_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign done       = (r_state == sac_pkg::ST_LOOKUP) && out_free;

    // Set RAM
    sac_ram #(
        .WIDTH (sac_pkg::ROW_BITS),
        .DEPTH (sac_pkg::SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (set_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_row = ram_rdata;

    sac_update u_update (
        .i_row  (rd_row),
        .i_tag  (r_tag),
        .i_kind (r_kind),
        .i_nw   (nw_eff),
        .o_row  (upd_row),
        .o_res  (upd_res)
    );

    // Sequencer: clear pass, then read / modify / write per request
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_re    = in_acc;
        ram_waddr = r_set;
        ram_wdata = upd_row;
        case (r_state)
            sac_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == sac_pkg::SET_BITS'(sac_pkg::SETS - 1)) begin
                    n_state = sac_pkg::ST_IDLE;
                end
            end
            sac_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = sac_pkg::ST_LOOKUP;
                end
            end
            sac_pkg::ST_LOOKUP: begin
                if (out_free) begin
                    ram_we  = 1'b1;
                    n_state = sac_pkg::ST_IDLE;
                end
            end
            default: n_state = sac_pkg::ST_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sac_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sac_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_set  <= set_idx;
            r_tag  <= tag_sh[sac_pkg::TAG_W-1:0];
            r_kind <= i_access_kind;
        end
        if (done) begin
            r_res <= upd_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind_echo = r_res.kind;
    assign o_hit       = r_res.hit;
    assign o_writeback = r_res.writeback;
    assign o_way       = r_res.way;

    // A read and a write of the set RAM never share a cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("set RAM read and write in the same cycle");

    // An accepted request is looked up in the next cycle
    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == sac_pkg::ST_LOOKUP))
        else $error("accepted request not in lookup");

    // A finished lookup shows its result in the next cycle
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> o_out_valid)
        else $error("lookup result not presented");

    // A hit never evicts
    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_writeback))
        else $error("writeback flagged on a hit");

    // No request is taken while the clearing pass runs
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sac_pkg::ST_CLEAR) |-> (!in_acc && !r_out_valid))
        else $error("request activity during clearing pass");

endmodule

`default_nettype wire
